FILE: hdl/hsl_pkg.sv
`default_nettype none

package hsl_pkg;

   // One request: a pixel in hue, saturation and lightness.
   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] lightness;
   } req_payload_type;

   // One result: the pixel in RGB888 and RGB565.
   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] packed_565;
   } rsp_payload_type;

   localparam int unsigned RSP_WIDTH = $bits(rsp_payload_type);

endpackage

`default_nettype wire

FILE: hdl/hsl_queue.sv
`default_nettype none

module hsl_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic      [WIDTH-1:0]           head_data,
   output logic                            empty,
   output logic      [$clog2(DEPTH+1)-1:0] count
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // Callers keep push below the depth; pop is honoured only with data present.
   assign do_push = push;
   assign do_pop  = pop && (count_ff != '0);

   // Pointer and occupancy updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries payload only, so it has no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = store_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

FILE: hdl/hsl_front.sv
`default_nettype none

module hsl_front #(
   parameter int unsigned FRACTION_BITS = 16,
   parameter int unsigned MID_DEPTH     = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire hsl_pkg::req_payload_type           req_payload,
   input  wire logic [$clog2(MID_DEPTH+1)-1:0]     mid_count,
   output logic                                    mid_push,
   output logic      [5*(FRACTION_BITS+1)-1:0]     mid_data
);

   import hsl_pkg::*;

   localparam int unsigned F      = FRACTION_BITS;
   localparam int unsigned TW     = F + 1;
   localparam int unsigned CW     = $clog2(MID_DEPTH+1);
   localparam int unsigned ONE_I  = 1 << F;
   localparam logic [TW-1:0] ONE   = TW'(ONE_I);
   localparam logic [TW-1:0] THIRD = TW'(ONE_I / 3);
   localparam logic [TW-1:0] HALF  = TW'(ONE_I / 2);

   logic          valid_ff, valid_in;
   logic [F-1:0]  h_ff, h_in;
   logic [F-1:0]  s_ff, s_in;
   logic [F-1:0]  l_ff, l_in;
   logic [F-1:0]  ls_ff, ls_in;
   logic [2*F-1:0] ls_full;
   logic          accept;
   logic [CW:0]   occupancy;

   logic [TW-1:0] s_w, l_w, ls_w, l2_w;
   logic [TW-1:0] q_raw, p_val, q_val;
   logic [TW-1:0] tr_sum, tr_val, tg_val, tb_val;

   // A request is taken only when the queue can hold it and the one in flight.
   assign occupancy = {1'b0, mid_count} + (CW+1)'(valid_ff);
   assign req_full  = (occupancy >= (CW+1)'(MID_DEPTH));
   assign accept    = req_push && !req_full;

   // Input stage: scale the bytes into fractions and form l times s.
   assign h_in    = {req_payload.hue, (F-8)'(0)};
   assign s_in    = {req_payload.saturation, (F-8)'(0)};
   assign l_in    = {req_payload.lightness, (F-8)'(0)};
   assign ls_full = l_in * s_in;
   assign ls_in   = ls_full[2*F-1:F];
   assign valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         h_ff  <= h_in;
         s_ff  <= s_in;
         l_ff  <= l_in;
         ls_ff <= ls_in;
      end
   end

   // Classification: grey pixels collapse both intermediates onto the lightness.
   always_comb begin
      s_w  = {1'b0, s_ff};
      l_w  = {1'b0, l_ff};
      ls_w = {1'b0, ls_ff};
      l2_w = {l_ff, 1'b0};
      if (l_w < HALF) begin
         q_raw = l_w + ls_w;
      end else begin
         q_raw = l_w + s_w - ls_w;
      end
      p_val = (l2_w > q_raw) ? l2_w - q_raw : '0;
      q_val = (q_raw < p_val) ? p_val : q_raw;
      if (s_ff == '0) begin
         p_val = l_w;
         q_val = l_w;
      end
   end

   // Hue offsets per channel; a red hue of exactly one is kept as is.
   always_comb begin
      tr_sum = {1'b0, h_ff} + THIRD;
      tr_val = (tr_sum > ONE) ? tr_sum - ONE : tr_sum;
      tg_val = {1'b0, h_ff};
      tb_val = ({1'b0, h_ff} < THIRD) ? {1'b0, h_ff} + ONE - THIRD
                                      : {1'b0, h_ff} - THIRD;
   end

   assign mid_push = valid_ff;
   assign mid_data = {p_val, q_val, tr_val, tg_val, tb_val};

endmodule

`default_nettype wire

FILE: hdl/hsl_back.sv
`default_nettype none

module hsl_back #(
   parameter int unsigned FRACTION_BITS = 16,
   parameter int unsigned OUT_DEPTH     = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               mid_empty,
   input  wire logic [5*(FRACTION_BITS+1)-1:0]     mid_data,
   output logic                                    mid_pop,
   input  wire logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
   output logic                                    out_push,
   output hsl_pkg::rsp_payload_type                out_data
);

   import hsl_pkg::*;

   localparam int unsigned F     = FRACTION_BITS;
   localparam int unsigned TW    = F + 1;
   localparam int unsigned KW    = F + 4;
   localparam int unsigned PRW   = TW + KW;
   localparam int unsigned VW    = F + 2;
   localparam int unsigned CHW   = VW + 8;
   localparam int unsigned CW    = $clog2(OUT_DEPTH+1);
   localparam int unsigned ONE_I = 1 << F;
   localparam logic [TW-1:0] SIXTH      = TW'(ONE_I / 6);
   localparam logic [TW-1:0] HALF       = TW'(ONE_I / 2);
   localparam logic [TW-1:0] TWO_THIRDS = TW'((2 * ONE_I) / 3);

   // Value taken outright, or the base of a ramp segment.
   function automatic logic [TW-1:0] seg_base(input logic [TW-1:0] t,
                                              input logic [TW-1:0] p,
                                              input logic [TW-1:0] q);
      logic [TW-1:0] r;
      if (t < SIXTH) begin
         r = p;
      end else if (t < HALF) begin
         r = q;
      end else begin
         r = p;
      end
      return r;
   endfunction

   // Ramp factor, six times the distance from the segment's p end, zero on flat parts.
   function automatic logic [KW-1:0] seg_factor(input logic [TW-1:0] t);
      logic [KW-1:0] x;
      logic [KW-1:0] r;
      x = '0;
      if (t < SIXTH) begin
         x = KW'(t);
      end else if (t >= HALF && t < TWO_THIRDS) begin
         x = KW'(TWO_THIRDS - t);
      end
      r = (x << 2) + (x << 1);
      return r;
   endfunction

   logic [TW-1:0]  p_w, q_w, d_w;
   logic [TW-1:0]  t_w [3];
   logic [CW+1:0]  occupancy;

   logic           v1_ff, v1_in;
   logic [TW-1:0]  base_ff [3];
   logic [TW-1:0]  base_in [3];
   logic [PRW-1:0] prod_ff [3];
   logic [PRW-1:0] prod_in [3];

   logic           v2_ff, v2_in;
   logic [7:0]     ch_ff [3];
   logic [7:0]     ch_in [3];
   logic [VW-1:0]  val_w [3];
   logic [CHW-1:0] scaled_w [3];

   // Credit check: the result queue must hold everything already in flight.
   assign occupancy = {2'b00, out_count} + (CW+2)'(v1_ff) + (CW+2)'(v2_ff);
   assign mid_pop   = !mid_empty && (occupancy < (CW+2)'(OUT_DEPTH));
   assign v1_in     = mid_pop;

   // Unpack the classified request.
   assign p_w    = mid_data[5*TW-1 -: TW];
   assign q_w    = mid_data[4*TW-1 -: TW];
   assign t_w[0] = mid_data[3*TW-1 -: TW];
   assign t_w[1] = mid_data[2*TW-1 -: TW];
   assign t_w[2] = mid_data[TW-1 -: TW];
   assign d_w    = q_w - p_w;

   // First stage: segment choice and the ramp product for each channel.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         base_in[c] = seg_base(t_w[c], p_w, q_w);
         prod_in[c] = PRW'(d_w) * PRW'(seg_factor(t_w[c]));
      end
   end

   // Second stage: add the ramp to its base and scale by 255.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         val_w[c]    = VW'(base_ff[c]) + VW'(prod_ff[c][PRW-1:F]);
         scaled_w[c] = (CHW'(val_w[c]) << 8) - CHW'(val_w[c]);
         ch_in[c]    = scaled_w[c][F+7:F];
      end
   end
   assign v2_in = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         base_ff[c] <= base_in[c];
         prod_ff[c] <= prod_in[c];
         ch_ff[c]   <= ch_in[c];
      end
   end

   // Result assembly, including the RGB565 packing.
   assign out_push            = v2_ff;
   assign out_data.red        = ch_ff[0];
   assign out_data.green      = ch_ff[1];
   assign out_data.blue       = ch_ff[2];
   assign out_data.packed_565 = {ch_ff[0][7:3], ch_ff[1][7:2], ch_ff[2][7:3]};

endmodule

`default_nettype wire

FILE: hdl/hsl_to_rgb_converter_top.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// request   in         req_push / req_full   req_payload (hue, saturation, lightness)
// result    out        rsp_pop / rsp_empty   rsp_payload (red, green, blue, packed_565)
//
// One request is taken every clock cycle while req_full is low; a result passes through
// the front input stage, the middle queue, two back stages and the result queue.
// The front runs ahead of the back through a MID_DEPTH entry queue, and the back
// issues work only while the OUT_DEPTH entry result queue has room for it.
// Reset is synchronous and clears only the queue pointers, queue counts and stage valid bits.
// When results are not popped, the result queue fills, then the middle queue,
// and req_full rises.
module hsl_to_rgb_converter_top #(
   parameter int unsigned FRACTION_BITS = 16,
   parameter int unsigned MID_DEPTH     = 4,
   parameter int unsigned OUT_DEPTH     = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire hsl_pkg::req_payload_type req_payload,
   input  wire logic                     rsp_pop,
   output logic                          rsp_empty,
   output hsl_pkg::rsp_payload_type      rsp_payload
);

   import hsl_pkg::*;

   localparam int unsigned MW = 5 * (FRACTION_BITS + 1);

   logic                             mid_push;
   logic [MW-1:0]                    mid_wdata;
   logic                             mid_pop;
   logic [MW-1:0]                    mid_rdata;
   logic                             mid_empty;
   logic [$clog2(MID_DEPTH+1)-1:0]   mid_count;

   logic                             out_push;
   rsp_payload_type                  out_wdata;
   logic [RSP_WIDTH-1:0]             out_rdata;
   logic [$clog2(OUT_DEPTH+1)-1:0]   out_count;

   // Front: accepts requests and works out the intermediates and hue offsets.
   hsl_front #(
      .FRACTION_BITS (FRACTION_BITS),
      .MID_DEPTH     (MID_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .mid_count   (mid_count),
      .mid_push    (mid_push),
      .mid_data    (mid_wdata)
   );

   // Queue between front and back.
   hsl_queue #(
      .WIDTH (MW),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wdata),
      .pop       (mid_pop),
      .head_data (mid_rdata),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   // Back: evaluates the channel segments and scales to bytes.
   hsl_back #(
      .FRACTION_BITS (FRACTION_BITS),
      .OUT_DEPTH     (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rdata),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_wdata)
   );

   // Result queue seen by the consumer.
   hsl_queue #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wdata),
      .pop       (rsp_pop),
      .head_data (out_rdata),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign rsp_payload = rsp_payload_type'(out_rdata);

endmodule

`default_nettype wire

FILE: test/hsl_to_rgb_checker.sv
`timescale 1ns / 1ps

module hsl_to_rgb_checker #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   input  wire logic                     req_full,
   input  wire hsl_pkg::req_payload_type req_payload,
   input  wire logic                     rsp_pop,
   input  wire logic                     rsp_empty,
   input  wire hsl_pkg::rsp_payload_type rsp_payload,
   output int unsigned                   mismatch_count,
   output int unsigned                   pending_count
);

   import hsl_pkg::*;

   // Fixed-point constants in unsigned Q(64-F).F with F = FRACTION_BITS, all rounded down.
   localparam logic [63:0] FX_ONE        = 64'd1 << FRACTION_BITS;
   localparam logic [63:0] FX_THIRD      = FX_ONE / 3;
   localparam logic [63:0] FX_SIXTH      = FX_ONE / 6;
   localparam logic [63:0] FX_HALF       = FX_ONE / 2;
   localparam logic [63:0] FX_TWO_THIRDS = (2 * FX_ONE) / 3;

   // Colours still owed by the converter, oldest first.
   rsp_payload_type owed_colours[$];
   int unsigned     colours_seen;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      colours_seen   = 0;
   end

   function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
      return (a * b) >> FRACTION_BITS;
   endfunction

   // Four-segment rule for one channel at hue position t.
   function automatic logic [63:0] channel_level(logic [63:0] t, logic [63:0] p,
                                                 logic [63:0] q);
      logic [63:0] span;
      span = q - p;
      if (t < FX_SIXTH)
         return p + frac_mul(span, 6 * t);
      if (t < FX_HALF)
         return q;
      if (t < FX_TWO_THIRDS)
         return p + frac_mul(span, 6 * (FX_TWO_THIRDS - t));
      return p;
   endfunction

   function automatic logic [7:0] to_byte(logic [63:0] level);
      logic [63:0] scaled;
      scaled = (level * 255) >> FRACTION_BITS;
      return scaled[7:0];
   endfunction

   // Works out the RGB colour of one HSL pixel.
   function automatic rsp_payload_type hsl_colour(req_payload_type px);
      logic [63:0]     h, s, l, q, p, ls, t_red, t_blue, r, g, b;
      rsp_payload_type colour;
      h = 64'(px.hue) << (FRACTION_BITS - 8);
      s = 64'(px.saturation) << (FRACTION_BITS - 8);
      l = 64'(px.lightness) << (FRACTION_BITS - 8);
      if (s == 0) begin
         r = l;
         g = l;
         b = l;
      end else begin
         ls = frac_mul(l, s);
         if (l < FX_HALF)
            q = l + ls;
         else
            q = l + s - ls;
         p = (2 * l > q) ? 2 * l - q : 64'd0;
         if (q < p)
            q = p;
         // Red wraps only when it passes one; blue wraps when it goes negative.
         t_red = h + FX_THIRD;
         if (t_red > FX_ONE)
            t_red = t_red - FX_ONE;
         t_blue = (h < FX_THIRD) ? h + FX_ONE - FX_THIRD : h - FX_THIRD;
         r = channel_level(t_red, p, q);
         g = channel_level(h, p, q);
         b = channel_level(t_blue, p, q);
      end
      colour.red        = to_byte(r);
      colour.green      = to_byte(g);
      colour.blue       = to_byte(b);
      colour.packed_565 = {colour.red[7:3], colour.green[7:2], colour.blue[7:3]};
      return colour;
   endfunction

   task automatic report_mismatch(string detail);
      $display("%0t: colour %0d: %s", $time, colours_seen, detail);
      mismatch_count = mismatch_count + 1;
   endtask

   // Check each popped colour against the oldest owed one, then record new requests.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (owed_colours.size() == 0) begin
               report_mismatch($sformatf("result %h with no request waiting", rsp_payload));
            end else begin
               want = owed_colours.pop_front();
               if (rsp_payload.red !== want.red)
                  report_mismatch($sformatf("red %h, expected %h",
                                            rsp_payload.red, want.red));
               if (rsp_payload.green !== want.green)
                  report_mismatch($sformatf("green %h, expected %h",
                                            rsp_payload.green, want.green));
               if (rsp_payload.blue !== want.blue)
                  report_mismatch($sformatf("blue %h, expected %h",
                                            rsp_payload.blue, want.blue));
               if (rsp_payload.packed_565 !== want.packed_565)
                  report_mismatch($sformatf("packed_565 %h, expected %h",
                                            rsp_payload.packed_565, want.packed_565));
            end
            colours_seen = colours_seen + 1;
         end
         if (req_push && !req_full)
            owed_colours.push_back(hsl_colour(req_payload));
      end
      pending_count = owed_colours.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import hsl_pkg::*;

   localparam int unsigned FRACTION_BITS  = 16;
   localparam int unsigned RANDOM_PIXELS  = 1130;
   localparam int unsigned STEADY_PIXELS  = 150;
   localparam int unsigned STALL_LIMIT    = 1000;
   localparam int unsigned SETTLE_CYCLES  = 12;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_push;
   logic            req_full;
   req_payload_type req_payload;
   logic            rsp_pop;
   logic            rsp_empty;
   rsp_payload_type rsp_payload;
   int unsigned     mismatch_total;
   int unsigned     owed_total;
   int unsigned     quiet_cycles;
   logic            steady_tail;

   hsl_to_rgb_converter_top #(
      .FRACTION_BITS(FRACTION_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_payload(req_payload),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_payload(rsp_payload)
   );

   hsl_to_rgb_checker #(
      .FRACTION_BITS(FRACTION_BITS)
   ) colour_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_payload   (req_payload),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_payload   (rsp_payload),
      .mismatch_count(mismatch_total),
      .pending_count (owed_total)
   );

   always #10 clock = ~clock;

   // Ends the run when neither side has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("hsl_to_rgb_converter_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one pixel, with an occasional gap before it, and waits until it is taken.
   task automatic send_pixel(logic [7:0] hue, logic [7:0] saturation,
                             logic [7:0] lightness);
      if (!steady_tail && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 9)) begin
            @(negedge clock);
            req_push <= 1'b0;
         end
      end
      @(negedge clock);
      req_push    <= 1'b1;
      req_payload <= '{hue: hue, saturation: saturation, lightness: lightness};
      @(posedge clock);
      while (req_full)
         @(posedge clock);
   endtask

   // Result side: stalls in short bursts, pops freely once the steady tail begins.
   initial begin
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!steady_tail && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 9)) begin
               @(negedge clock);
               rsp_pop <= 1'b0;
            end
         end
         repeat ($urandom_range(1, 30)) begin
            @(negedge clock);
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      logic [7:0] hue_edges[10];
      logic [7:0] hue, saturation, lightness;
      hue_edges   = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd127, 8'd128, 8'd170,
                      8'd171, 8'd255};
      reset       = 1'b1;
      req_push    = 1'b0;
      req_payload = '0;
      steady_tail = 1'b0;
      quiet_cycles = 0;
      repeat (6)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pixels: extremes, grey, the lightness split and every hue segment edge.
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd77,  8'd0,   8'd128);
      send_pixel(8'd200, 8'd0,   8'd127);
      send_pixel(8'd0,   8'd255, 8'd127);
      send_pixel(8'd0,   8'd255, 8'd128);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd42,  8'd200, 8'd100);
      send_pixel(8'd43,  8'd200, 8'd100);
      send_pixel(8'd85,  8'd180, 8'd160);
      send_pixel(8'd86,  8'd180, 8'd160);
      send_pixel(8'd127, 8'd255, 8'd200);
      send_pixel(8'd128, 8'd255, 8'd200);
      send_pixel(8'd170, 8'd90,  8'd60);
      send_pixel(8'd171, 8'd90,  8'd60);
      send_pixel(8'd255, 8'd1,   8'd1);
      send_pixel(8'd1,   8'd255, 8'd254);
      send_pixel(8'd213, 8'd128, 8'd64);
      send_pixel(8'd213, 8'd1,   8'd255);

      // Random pixels, leaning towards grey, the lightness split and hue edges.
      for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
         if (n == RANDOM_PIXELS - STEADY_PIXELS)
            steady_tail = 1'b1;
         hue        = 8'($urandom_range(0, 255));
         saturation = 8'($urandom_range(0, 255));
         lightness  = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 9))
            0: saturation = 8'd0;
            1: lightness = 8'($urandom_range(126, 129));
            2: hue = hue_edges[4'($urandom_range(0, 9))];
            default: ;
         endcase
         send_pixel(hue, saturation, lightness);
      end
      @(negedge clock);
      req_push <= 1'b0;

      // Drain the converter, then allow for its pipeline before the verdict.
      while (owed_total != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES)
         @(negedge clock);
      if (mismatch_total == 0)
         $display("hsl_to_rgb_converter_top verification clean");
      else
         $display("hsl_to_rgb_converter_top verification failed");
      $finish;
   end

endmodule
